// ===== src/hsvbtc_pkg.sv =====
// ----------------------------------------------------------------------------
// hsvbtc_pkg
// shared types, widths and constants of the hsv box threshold centroid block
// ----------------------------------------------------------------------------
package hsvbtc_pkg;

  localparam int unsigned MaxColsDef = 2048;
  localparam int unsigned MaxRowsDef = 2048;

  localparam int unsigned ChW      = 8;
  localparam int unsigned LwW      = 12;
  localparam int unsigned CoordW   = 11;
  localparam int unsigned HitsW    = 23;
  localparam int unsigned SumW     = 34;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned StepW    = 4;

  localparam logic [ChW-1:0]    MaskHit  = 8'd255;
  localparam logic [ChW-1:0]    MaskMiss = 8'd100;
  localparam logic [HitsW-1:0]  HitsMax  = '1;
  localparam logic [SumW-1:0]   SumMax   = '1;
  localparam logic [CoordW-1:0] CoordMax = '1;
  localparam logic [StepW-1:0]  SatStep  = StepW'(CoordW);

  typedef enum logic [CfgAddrW-1:0] {
    REG_HUE_LOW,
    REG_SAT_LOW,
    REG_VAL_LOW,
    REG_HUE_HIGH,
    REG_SAT_HIGH,
    REG_VAL_HIGH,
    REG_LINE_WIDTH,
    REG_CENTROID_EN
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0][ChW-1:0] lo;
    logic [2:0][ChW-1:0] hi;
    logic [LwW-1:0]      line_width;
    logic                centroid_en;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [SumW-1:0]   col_sum;
    logic [SumW-1:0]   row_sum;
    logic [HitsW-1:0]  count;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
  } div_res_t;

  typedef enum logic {
    BK_IDLE,
    BK_DIV
  } back_state_e;

endpackage

// ===== src/hsvbtc_fifo.sv =====
// ----------------------------------------------------------------------------
// hsvbtc_fifo
// two-entry queue between the classifying front and the accumulating back
// ----------------------------------------------------------------------------
module hsvbtc_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             valid_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== src/hsvbtc_front.sv =====
// ----------------------------------------------------------------------------
// hsvbtc_front
// range check of each pixel and raster column and row tracking
// ----------------------------------------------------------------------------
module hsvbtc_front #(
  parameter int unsigned MAX_COLS = hsvbtc_pkg::MaxColsDef,
  parameter int unsigned MAX_ROWS = hsvbtc_pkg::MaxRowsDef,
  localparam int unsigned CW = $clog2(MAX_COLS),
  localparam int unsigned RW = $clog2(MAX_ROWS)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  hsvbtc_pkg::cfg_t       cfg_i,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [2:0][7:0]        ch_i,
  input  logic                   last_i,
  output logic                   push_o,
  output logic [CW+RW+1:0]       entry_o,
  input  logic                   full_i
);

  import hsvbtc_pkg::*;

  localparam int unsigned EW = (CW + 1 > LwW) ? CW + 1 : LwW;

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          hit;
  logic          accept;
  logic [EW-1:0] lw_ext, eff_w, col_inc;

  assign ready_o = !full_i;
  assign accept  = valid_i && !full_i;
  assign push_o  = accept;

  always_comb begin
    hit = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (ch_i[i] < cfg_i.lo[i] || ch_i[i] > cfg_i.hi[i]) begin
        hit = 1'b0;
      end
    end
  end

  assign entry_o = {hit, last_i, row_q, col_q};

  always_comb begin
    lw_ext  = EW'(cfg_i.line_width);
    col_inc = EW'(col_q) + EW'(1);
    if (lw_ext == '0) begin
      eff_w = EW'(1);
    end else if (lw_ext > EW'(MAX_COLS)) begin
      eff_w = EW'(MAX_COLS);
    end else begin
      eff_w = lw_ext;
    end
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_i) begin
        col_d = '0;
        row_d = '0;
      end else if (col_inc >= eff_w) begin
        col_d = '0;
        if (row_q != RW'(MAX_ROWS - 1)) begin
          row_d = row_q + RW'(1);
        end
      end else begin
        col_d = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ===== src/hsvbtc_div.sv =====
// ----------------------------------------------------------------------------
// hsvbtc_div
// two-lane restoring divider, one quotient bit per cycle, saturating at 2047
// ----------------------------------------------------------------------------
module hsvbtc_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hsvbtc_pkg::div_req_t req_i,
  output hsvbtc_pkg::div_res_t res_o
);

  import hsvbtc_pkg::*;

  logic [SumW-1:0]   rem_q [2];
  logic [CoordW-1:0] quo_q [2];
  logic              sat_q [2];
  logic [SumW-1:0]   dsr_q;
  logic [StepW-1:0]  step_q;
  logic              busy_q;
  logic              done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= SatStep;
      end else if (busy_q) begin
        step_q <= step_q - StepW'(1);
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q[0] <= req_i.col_sum;
      rem_q[1] <= req_i.row_sum;
      dsr_q    <= {req_i.count, CoordW'(0)};
    end else if (busy_q) begin
      dsr_q <= dsr_q >> 1;
      for (int l = 0; l < 2; l++) begin
        if (step_q == SatStep) begin
          sat_q[l] <= (rem_q[l] >= dsr_q);
        end else begin
          if (rem_q[l] >= dsr_q) begin
            rem_q[l] <= rem_q[l] - dsr_q;
          end
          quo_q[l] <= {quo_q[l][CoordW-2:0], (rem_q[l] >= dsr_q)};
        end
      end
    end
  end

  assign res_o.done = done_q;
  assign res_o.col  = sat_q[0] ? CoordMax : quo_q[0];
  assign res_o.row  = sat_q[1] ? CoordMax : quo_q[1];

endmodule

// ===== src/hsvbtc_back.sv =====
// ----------------------------------------------------------------------------
// hsvbtc_back
// frame accumulators, centroid sequencing and the output register
// ----------------------------------------------------------------------------
module hsvbtc_back #(
  parameter int unsigned MAX_COLS = hsvbtc_pkg::MaxColsDef,
  parameter int unsigned MAX_ROWS = hsvbtc_pkg::MaxRowsDef,
  localparam int unsigned CW = $clog2(MAX_COLS),
  localparam int unsigned RW = $clog2(MAX_ROWS)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  hsvbtc_pkg::cfg_t       cfg_i,
  input  logic                   q_valid_i,
  input  logic [CW+RW+1:0]       q_entry_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [55:0]            out_data_o,
  output logic                   out_last_o
);

  import hsvbtc_pkg::*;

  back_state_e state_q, state_d;

  logic [CW-1:0]     e_col;
  logic [RW-1:0]     e_row;
  logic              e_last, e_hit;

  logic [HitsW-1:0]  hits_q, hits_new;
  logic [SumW-1:0]   csum_q, csum_new;
  logic [SumW-1:0]   rsum_q, rsum_new;
  logic [SumW:0]     csum_add, rsum_add;
  logic [CoordW-1:0] held_col_q, held_row_q;

  logic              st_hit_q, st_last_q;
  logic [HitsW-1:0]  st_hits_q;

  logic              out_valid_q;
  logic [ChW-1:0]    o_mask_q;
  logic              o_hit_q, o_upd_q, o_empty_q, o_last_q;
  logic [CoordW-1:0] o_col_q, o_row_q;
  logic [HitsW-1:0]  o_hits_q;

  logic              need_div, pop, load_direct, load_div;
  div_req_t          div_req;
  div_res_t          div_res;

  assign {e_hit, e_last, e_row, e_col} = q_entry_i;

  always_comb begin
    csum_add = {1'b0, csum_q} + (SumW + 1)'(e_col);
    rsum_add = {1'b0, rsum_q} + (SumW + 1)'(e_row);
    hits_new = hits_q;
    csum_new = csum_q;
    rsum_new = rsum_q;
    if (e_hit) begin
      if (hits_q != HitsMax) begin
        hits_new = hits_q + HitsW'(1);
      end
      csum_new = (csum_add > (SumW + 1)'(SumMax)) ? SumMax : csum_add[SumW-1:0];
      rsum_new = (rsum_add > (SumW + 1)'(SumMax)) ? SumMax : rsum_add[SumW-1:0];
    end
    need_div = e_last && (hits_new != '0) && cfg_i.centroid_en;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (pop && need_div) begin
          state_d = BK_DIV;
        end
      end
      BK_DIV: begin
        if (div_res.done) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop         = 1'b0;
    load_div    = 1'b0;
    unique case (state_q)
      BK_IDLE: pop      = q_valid_i && (!out_valid_q || out_ready_i);
      BK_DIV:  load_div = div_res.done;
      default: pop      = 1'b0;
    endcase
    load_direct = pop && !need_div;
  end

  assign q_pop_o         = pop;
  assign div_req.start   = pop && need_div;
  assign div_req.col_sum = csum_new;
  assign div_req.row_sum = rsum_new;
  assign div_req.count   = hits_new;

  hsvbtc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      hits_q      <= '0;
      csum_q      <= '0;
      rsum_q      <= '0;
      held_col_q  <= '0;
      held_row_q  <= '0;
    end else begin
      state_q <= state_d;
      if (load_direct || load_div) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop) begin
        if (e_last) begin
          hits_q <= '0;
          csum_q <= '0;
          rsum_q <= '0;
        end else begin
          hits_q <= hits_new;
          csum_q <= csum_new;
          rsum_q <= rsum_new;
        end
      end
      if (load_div) begin
        held_col_q <= div_res.col;
        held_row_q <= div_res.row;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_req.start) begin
      st_hit_q  <= e_hit;
      st_last_q <= e_last;
      st_hits_q <= hits_new;
    end
    if (load_direct) begin
      o_mask_q  <= e_hit ? MaskHit : MaskMiss;
      o_hit_q   <= e_hit;
      o_col_q   <= held_col_q;
      o_row_q   <= held_row_q;
      o_upd_q   <= 1'b0;
      o_empty_q <= e_last && (hits_new == '0);
      o_hits_q  <= hits_new;
      o_last_q  <= e_last;
    end else if (load_div) begin
      o_mask_q  <= st_hit_q ? MaskHit : MaskMiss;
      o_hit_q   <= st_hit_q;
      o_col_q   <= div_res.col;
      o_row_q   <= div_res.row;
      o_upd_q   <= 1'b1;
      o_empty_q <= 1'b0;
      o_hits_q  <= st_hits_q;
      o_last_q  <= st_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_last_o  = o_last_q;
  assign out_data_o  = {o_hits_q, o_empty_q, o_upd_q, o_row_q, o_col_q, o_hit_q, o_mask_q};

endmodule

// ===== src/hsv_box_threshold_centroid_core.sv =====
// ----------------------------------------------------------------------------
// hsv_box_threshold_centroid_core
// hsv box threshold with per-frame blob centroid
//
// pixels enter on the s_axis channel in raster order, one word per pixel,
// tlast on the last pixel of a frame. every pixel gives one result word on
// m_axis: mask byte, in-range flag, held centroid, frame-end flags, hit count.
// the front checks the pixel against the bounds and tracks column and row,
// a two-word queue feeds the back, which accumulates and drives the output
// register. a pixel passes the queue into the output register; one pixel per
// cycle sustained while the receiver is ready and no divide runs. a frame end
// with centroid enabled and hits present runs the two-lane divider, one
// quotient bit a cycle, while the back takes no word and the queue fills.
// reset clears counters, sums and the held centroid and loads the register
// defaults. a stalled receiver holds the output word; the back stops popping,
// the queue fills and s_axis_tready drops.
// config writes: cfg_we_i, cfg_addr_i index, cfg_wdata_i, only while idle.
// ----------------------------------------------------------------------------
module hsv_box_threshold_centroid_core #(
  parameter int unsigned MAX_COLS = hsvbtc_pkg::MaxColsDef,
  parameter int unsigned MAX_ROWS = hsvbtc_pkg::MaxRowsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hsvbtc_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [hsvbtc_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // hue[7:0], saturation[15:8], brightness[23:16]
  input  logic [23:0]                     s_axis_tdata,
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // mask_byte[7:0], in_range[8], center_col[19:9], center_row[30:20],
  // center_updated[31], empty_frame[32], hit_count[55:33]
  output logic [55:0]                     m_axis_tdata,
  output logic                            m_axis_tlast
);

  import hsvbtc_pkg::*;

  localparam int unsigned CW = $clog2(MAX_COLS);
  localparam int unsigned RW = $clog2(MAX_ROWS);
  localparam int unsigned EntW = CW + RW + 2;

  cfg_t            cfg_q;
  logic            push, full, pop, q_valid;
  logic [EntW-1:0] push_entry, pop_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lo[0]       <= 8'd0;
      cfg_q.lo[1]       <= 8'd0;
      cfg_q.lo[2]       <= 8'd110;
      cfg_q.hi[0]       <= 8'd255;
      cfg_q.hi[1]       <= 8'd255;
      cfg_q.hi[2]       <= 8'd255;
      cfg_q.line_width  <= 12'd640;
      cfg_q.centroid_en <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_HUE_LOW:     cfg_q.lo[0]       <= cfg_wdata_i[ChW-1:0];
        REG_SAT_LOW:     cfg_q.lo[1]       <= cfg_wdata_i[ChW-1:0];
        REG_VAL_LOW:     cfg_q.lo[2]       <= cfg_wdata_i[ChW-1:0];
        REG_HUE_HIGH:    cfg_q.hi[0]       <= cfg_wdata_i[ChW-1:0];
        REG_SAT_HIGH:    cfg_q.hi[1]       <= cfg_wdata_i[ChW-1:0];
        REG_VAL_HIGH:    cfg_q.hi[2]       <= cfg_wdata_i[ChW-1:0];
        REG_LINE_WIDTH:  cfg_q.line_width  <= cfg_wdata_i[LwW-1:0];
        REG_CENTROID_EN: cfg_q.centroid_en <= cfg_wdata_i[0];
        default:         cfg_q             <= cfg_q;
      endcase
    end
  end

  hsvbtc_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .ch_i    (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .push_o  (push),
    .entry_o (push_entry),
    .full_i  (full)
  );

  hsvbtc_fifo #(
    .Width (EntW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (pop_entry),
    .valid_o (q_valid)
  );

  hsvbtc_back #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_entry_i   (pop_entry),
    .q_pop_o     (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule
